// ===== src/sirq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared IRQ owner tracker package
// Sizes, codes, table row layout and controller/datapath interface types.
// ----------------------------------------------------------------------------
package sirq_pkg;

   localparam int OWNERS_PER_LINE = 4;
   localparam int LINE_COUNT      = 16;
   localparam int ID_BITS         = 16;

   localparam int LINE_W    = $clog2(LINE_COUNT);
   localparam int SLOT_W    = (OWNERS_PER_LINE > 1) ? $clog2(OWNERS_PER_LINE) : 1;
   localparam int ALIVE_W   = 64;
   localparam int BIT_IDX_W = 8;
   localparam int OUT_SLOTS = 4;
   localparam int FIELD_W   = 16;
   localparam int SHOW_W    = OUT_SLOTS * ID_BITS;

   typedef logic [2:0] action_type;
   localparam action_type ACT_BIND       = 3'd0;
   localparam action_type ACT_DONE       = 3'd1;
   localparam action_type ACT_UNBIND     = 3'd2;
   localparam action_type ACT_UNBIND_ALL = 3'd3;
   localparam action_type ACT_DISPATCH   = 3'd4;

   typedef logic [1:0] status_type;
   localparam status_type ST_OK        = 2'd0;
   localparam status_type ST_NOT_OWNER = 2'd1;
   localparam status_type ST_NO_SLOT   = 2'd2;

   typedef logic [1:0] kind_type;
   localparam kind_type KIND_NONE      = 2'd0;
   localparam kind_type KIND_KERNEL    = 2'd1;
   localparam kind_type KIND_OWNERS    = 2'd2;
   localparam kind_type KIND_UNHANDLED = 2'd3;

   typedef enum logic [1:0] {
      MODE_LINE,
      MODE_SWEEP,
      MODE_SHOW
   } mode_type;

   typedef struct packed {
      logic [OWNERS_PER_LINE-1:0]              ack;
      logic [OWNERS_PER_LINE-1:0][ID_BITS-1:0] ids;
   } row_type;

   typedef struct packed {
      logic              load;
      logic              rd;
      logic              sweep_addr;
      logic              exec;
      mode_type          mode;
      logic [LINE_W-1:0] sweep_line;
   } cmd_type;

   typedef struct packed {
      logic unbind_all;
   } sts_type;

endpackage

// ===== src/sirq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared IRQ owner tracker controller
// Sequences table reads and updates, sweeps all lines for unbind-all.
// ----------------------------------------------------------------------------
module sirq_ctrl import sirq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   output logic    rsp_valid,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [4:0] {
      S_IDLE    = 5'b00001,
      S_READ    = 5'b00010,
      S_EXEC    = 5'b00100,
      S_SHOW_RD = 5'b01000,
      S_SHOW    = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   logic [LINE_W-1:0] cnt_ff, cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      rsp_valid_in   = 1'b0;
      cmd            = '0;
      cmd.mode       = MODE_LINE;
      cmd.sweep_line = cnt_ff;
      unique case (state_ff)
         S_IDLE: begin
            cmd.load = start;
            cnt_in   = '0;
            if (start) state_in = S_READ;
         end
         S_READ: begin
            cmd.rd         = 1'b1;
            cmd.sweep_addr = sts.unbind_all;
            state_in       = S_EXEC;
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            if (sts.unbind_all) begin
               cmd.mode = MODE_SWEEP;
               cnt_in   = cnt_ff + 1'b1;
               state_in = (cnt_ff == LINE_W'(LINE_COUNT - 1)) ? S_SHOW_RD : S_READ;
            end else begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_SHOW_RD: begin
            cmd.rd   = 1'b1;
            state_in = S_SHOW;
         end
         S_SHOW: begin
            cmd.exec     = 1'b1;
            cmd.mode     = MODE_SHOW;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== src/sirq_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared IRQ owner tracker datapath
// Owner/ack row memory, line enables, handler register and update logic.
// ----------------------------------------------------------------------------
module sirq_dp import sirq_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  cmd_type       cmd,
   output sts_type       sts,
   input  logic [2:0]    req_action,
   input  logic [3:0]    req_line,
   input  logic [15:0]   req_owner_id,
   input  logic [63:0]   req_alive_slots,
   input  logic [3:0]    req_delivered_slots,
   input  logic          csr_wr,
   input  logic [15:0]   csr_wdata,
   output logic [1:0]    rsp_status,
   output logic [1:0]    rsp_dispatch_kind,
   output logic [3:0]    rsp_notify_slots,
   output logic [15:0]   rsp_notify_id_0,
   output logic [15:0]   rsp_notify_id_1,
   output logic [15:0]   rsp_notify_id_2,
   output logic [15:0]   rsp_notify_id_3,
   output logic [3:0]    rsp_pending_slots,
   output logic [15:0]   rsp_line_enables
);

   typedef struct packed {
      logic              hit;
      logic [SLOT_W-1:0] slot;
   } find_type;

   typedef logic [OWNERS_PER_LINE-1:0] slot_mask_type;

   action_type          action_ff;
   logic [3:0]          line_ff;
   logic [ID_BITS-1:0]  id_ff;
   logic [ALIVE_W-1:0]  alive_ff;
   logic [3:0]          deliv_ff;
   logic [15:0]         khl_ff;
   logic [LINE_COUNT-1:0] en_ff, en_in;
   logic [LINE_COUNT-1:0] row_vld_ff;

   row_type             mem [LINE_COUNT];
   row_type             rd_row_ff;
   logic                rd_vld_ff;
   logic [LINE_W-1:0]   addr_ff;
   logic [LINE_W-1:0]   rd_addr;

   status_type          status_ff;
   kind_type            kind_ff;
   logic [3:0]          notify_ff;
   logic [OUT_SLOTS-1:0][ID_BITS-1:0] ids_ff;
   logic [3:0]          pend_ff;
   logic [15:0]         en_out_ff;

   row_type             cur, p, q, nr;
   slot_mask_type       ok, occ, deliv;
   find_type            fc, fb, ff;
   logic                line_ok, bad, wr, found, en_b;
   status_type          st;
   kind_type            kd;
   logic [3:0]          nt;
   logic [OUT_SLOTS-1:0][ID_BITS-1:0] shown;

   function automatic slot_mask_type alive_ok(logic [ALIVE_W-1:0] alive,
                                              logic [LINE_W-1:0] ln);
      slot_mask_type          r;
      logic [BIT_IDX_W-1:0]   idx;
      for (int s = 0; s < OWNERS_PER_LINE; s++) begin
         idx  = BIT_IDX_W'(ln) * BIT_IDX_W'(OWNERS_PER_LINE) + BIT_IDX_W'(s);
         r[s] = (idx[BIT_IDX_W-1:6] != '0) || alive[idx[5:0]];
      end
      return r;
   endfunction

   function automatic slot_mask_type occupied(row_type r);
      slot_mask_type m;
      for (int s = 0; s < OWNERS_PER_LINE; s++) m[s] = (r.ids[s] != '0);
      return m;
   endfunction

   function automatic row_type purge(row_type r, slot_mask_type live);
      row_type o;
      o = r;
      for (int s = 0; s < OWNERS_PER_LINE; s++) begin
         if (r.ids[s] != '0 && !live[s]) begin
            o.ids[s] = '0;
            o.ack[s] = 1'b0;
         end
      end
      return o;
   endfunction

   function automatic find_type find_slot(row_type r, logic [ID_BITS-1:0] key);
      find_type f;
      f = '0;
      for (int s = OWNERS_PER_LINE - 1; s >= 0; s--) begin
         if (r.ids[s] == key) begin
            f.hit  = 1'b1;
            f.slot = SLOT_W'(s);
         end
      end
      return f;
   endfunction

   // capture request word
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff <= req_action;
         line_ff   <= req_line;
         id_ff     <= ID_BITS'(req_owner_id);
         alive_ff  <= req_alive_slots;
         deliv_ff  <= req_delivered_slots;
      end
   end

   assign sts.unbind_all = (action_ff == ACT_UNBIND_ALL);
   assign line_ok        = ({1'b0, line_ff} < 5'(LINE_COUNT));
   assign bad            = !line_ok || (id_ff == '0);
   assign rd_addr        = cmd.sweep_addr ? cmd.sweep_line : line_ff[LINE_W-1:0];

   // row memory, registered read
   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         rd_row_ff <= mem[rd_addr];
         rd_vld_ff <= row_vld_ff[rd_addr];
         addr_ff   <= rd_addr;
      end
      if (cmd.exec && wr) mem[addr_ff] <= nr;
   end

   assign cur = rd_vld_ff ? rd_row_ff : '0;

   always_comb begin
      ok    = alive_ok(alive_ff, addr_ff);
      occ   = occupied(cur);
      deliv = OWNERS_PER_LINE'(deliv_ff);
      fc    = find_slot(cur, id_ff);
      fb    = '0;
      ff    = '0;
      p     = cur;
      q     = cur;
      nr    = cur;
      en_b  = en_ff[addr_ff];
      st    = ST_OK;
      kd    = KIND_NONE;
      nt    = '0;
      wr    = 1'b0;
      found = 1'b0;
      case (cmd.mode)
         MODE_LINE: begin
            case (action_ff)
               ACT_BIND: begin
                  if (bad) begin
                     st = ST_NOT_OWNER;
                  end else begin
                     wr = 1'b1;
                     p  = purge(cur, ok);
                     fb = find_slot(p, id_ff);
                     ff = find_slot(p, '0);
                     if (fb.hit) begin
                        en_b = 1'b1;
                     end else if (!ff.hit) begin
                        st = ST_NO_SLOT;
                     end else begin
                        p.ids[ff.slot] = id_ff;
                        p.ack[ff.slot] = 1'b0;
                        en_b           = 1'b1;
                     end
                     nr = p;
                  end
               end
               ACT_DONE: begin
                  if (bad || !fc.hit) begin
                     st = ST_NOT_OWNER;
                  end else begin
                     wr             = 1'b1;
                     p.ack[fc.slot] = 1'b0;
                     q              = purge(p, ok);
                     if (q.ack == '0) en_b = 1'b1;
                     nr = q;
                  end
               end
               ACT_UNBIND: begin
                  if (bad || !fc.hit) begin
                     st = ST_NOT_OWNER;
                  end else begin
                     wr             = 1'b1;
                     p.ids[fc.slot] = '0;
                     p.ack[fc.slot] = 1'b0;
                     q              = purge(p, ok);
                     if (occupied(q) == '0) en_b = 1'b0;
                     else if (q.ack == '0) en_b = 1'b1;
                     nr = q;
                  end
               end
               ACT_DISPATCH: begin
                  if (!line_ok) begin
                     kd = KIND_UNHANDLED;
                  end else if (khl_ff[line_ff]) begin
                     kd = KIND_KERNEL;
                  end else if (occ == '0) begin
                     kd = KIND_UNHANDLED;
                  end else begin
                     kd    = KIND_OWNERS;
                     wr    = 1'b1;
                     en_b  = 1'b0;
                     p.ack = occ & deliv;
                     nt    = 4'(occ);
                     nr    = p;
                  end
               end
               default: ;
            endcase
         end
         MODE_SWEEP: begin
            if (id_ff != '0) begin
               for (int s = 0; s < OWNERS_PER_LINE; s++) begin
                  if (cur.ids[s] == id_ff) begin
                     p.ids[s] = '0;
                     p.ack[s] = 1'b0;
                     found    = 1'b1;
                  end
               end
            end
            if (found) begin
               wr = 1'b1;
               q  = purge(p, ok);
               if (occupied(q) == '0) en_b = 1'b0;
               else if (q.ack == '0) en_b = 1'b1;
               nr = q;
            end
         end
         default: ;
      endcase
      en_in          = en_ff;
      en_in[addr_ff] = en_b;
      shown          = line_ok ? SHOW_W'(nr.ids) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         khl_ff     <= '0;
         en_ff      <= '0;
         row_vld_ff <= '0;
      end else begin
         if (csr_wr) khl_ff <= csr_wdata;
         if (cmd.exec) en_ff <= en_in;
         if (cmd.exec && wr) row_vld_ff[addr_ff] <= 1'b1;
      end
   end

   // result word
   always_ff @(posedge clock) begin
      if (cmd.exec && cmd.mode != MODE_SWEEP) begin
         status_ff <= st;
         kind_ff   <= kd;
         notify_ff <= nt;
         ids_ff    <= shown;
         pend_ff   <= line_ok ? 4'(nr.ack) : 4'd0;
         en_out_ff <= 16'(en_in);
      end
   end

   assign rsp_status        = status_ff;
   assign rsp_dispatch_kind = kind_ff;
   assign rsp_notify_slots  = notify_ff;
   assign rsp_notify_id_0   = FIELD_W'(ids_ff[0]);
   assign rsp_notify_id_1   = FIELD_W'(ids_ff[1]);
   assign rsp_notify_id_2   = FIELD_W'(ids_ff[2]);
   assign rsp_notify_id_3   = FIELD_W'(ids_ff[3]);
   assign rsp_pending_slots = pend_ff;
   assign rsp_line_enables  = en_out_ff;

endmodule

// ===== src/shared_irq_owner_ack_tracker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared IRQ owner and acknowledge tracker
// Owner slots, acknowledge masks and enables for shared interrupt lines.
//
//   Channel   Ports                      Handshake
//   request   start, busy, req_*         taken when start & !busy
//   result    rsp_valid, rsp_*           one-cycle strobe, no backpressure
//   config    csr_valid, csr_ready, csr_wdata taken when valid & ready
//
// Bind, done, unbind and dispatch pass through the read and execute states
// before the strobe. Unbind-all reads every line of the row memory in turn,
// writes back each line that held the owner, then rereads the requested line.
// busy is low in the strobe cycle, so the next word may start there.
// Reset clears row valid bits at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module shared_irq_owner_ack_tracker import sirq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_action,
   input  logic [3:0]  req_line,
   input  logic [15:0] req_owner_id,
   input  logic [63:0] req_alive_slots,
   input  logic [3:0]  req_delivered_slots,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [1:0]  rsp_dispatch_kind,
   output logic [3:0]  rsp_notify_slots,
   output logic [15:0] rsp_notify_id_0,
   output logic [15:0] rsp_notify_id_1,
   output logic [15:0] rsp_notify_id_2,
   output logic [15:0] rsp_notify_id_3,
   output logic [3:0]  rsp_pending_slots,
   output logic [15:0] rsp_line_enables,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_wdata
);

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   sirq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .sts       (sts),
      .cmd       (cmd)
   );

   sirq_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_action          (req_action),
      .req_line            (req_line),
      .req_owner_id        (req_owner_id),
      .req_alive_slots     (req_alive_slots),
      .req_delivered_slots (req_delivered_slots),
      .csr_wr              (csr_valid & csr_ready),
      .csr_wdata           (csr_wdata),
      .rsp_status          (rsp_status),
      .rsp_dispatch_kind   (rsp_dispatch_kind),
      .rsp_notify_slots    (rsp_notify_slots),
      .rsp_notify_id_0     (rsp_notify_id_0),
      .rsp_notify_id_1     (rsp_notify_id_1),
      .rsp_notify_id_2     (rsp_notify_id_2),
      .rsp_notify_id_3     (rsp_notify_id_3),
      .rsp_pending_slots   (rsp_pending_slots),
      .rsp_line_enables    (rsp_line_enables)
   );

endmodule

// ===== src/sirq_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared IRQ owner tracker port checker
// Port-level properties of the command and result channels.
// ----------------------------------------------------------------------------
module sirq_chk import sirq_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_valid,
   input logic [1:0] rsp_status,
   input logic [1:0] rsp_dispatch_kind,
   input logic [3:0] rsp_notify_slots
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted word did not raise busy");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while still busy");

   a_dispatch_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dispatch_kind != KIND_NONE |-> rsp_status == ST_OK)
      else $error("dispatch result with error status");

   a_notify_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dispatch_kind != KIND_OWNERS |-> rsp_notify_slots == 4'd0)
      else $error("notify slots set without owner dispatch");

endmodule

bind shared_irq_owner_ack_tracker sirq_chk u_sirq_chk (.*);
